/* hw/rtl/rsfs_pkg.sv */
package rsfs_pkg;

    localparam int HOLD_LEN = 4;
    localparam int FILL_W = 3;
    localparam logic [7:0] SUM_TARGET = 8'hFF;
    localparam logic [15:0] ERR_MAX = 16'hFFFF;

    typedef struct packed {
        logic               frame_good;
        logic signed [23:0] rate_sample;
        logic [7:0]         status_bits;
        logic               run_start;
        logic [15:0]        error_total;
    } result_t;

endpackage

/* hw/rtl/rsfs_core.sv */
module rsfs_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    output logic             has_result,
    output rsfs_pkg::result_t result
);

    logic [7:0] window_reg [rsfs_pkg::HOLD_LEN];
    logic [7:0] window_next [rsfs_pkg::HOLD_LEN];
    logic [rsfs_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic [15:0] err_reg, err_next;
    logic run_active_reg, run_active_next;
    logic restart_reg, restart_next;

    logic [7:0] sum;
    logic good;
    logic [15:0] err_inc;

    assign has_result = (fill_reg == rsfs_pkg::FILL_W'(rsfs_pkg::HOLD_LEN));
    // low 8 bits of the five-byte sum, wrap is intended
    assign sum = rx_byte + window_reg[0] + window_reg[1] + window_reg[2] + window_reg[3];
    assign good = (sum == rsfs_pkg::SUM_TARGET);
    assign err_inc = (err_reg == rsfs_pkg::ERR_MAX) ? err_reg : err_reg + 16'd1;

    always_comb begin
        result.frame_good  = good;
        result.rate_sample = good ? {window_reg[0], window_reg[1], window_reg[2]} : 24'sd0;
        result.status_bits = good ? window_reg[3] : 8'd0;
        result.run_start   = good ? restart_reg : 1'b0;
        result.error_total = good ? err_reg : err_inc;
    end

    always_comb begin
        window_next     = window_reg;
        fill_next       = fill_reg;
        err_next        = err_reg;
        run_active_next = run_active_reg;
        restart_next    = restart_reg;
        if (step) begin
            priority if (!has_result) begin
                window_next[fill_reg[1:0]] = rx_byte;
                fill_next = fill_reg + 1'b1;
            end else if (good) begin
                for (int i = 0; i < rsfs_pkg::HOLD_LEN; i++) begin
                    window_next[i] = 8'd0;
                end
                fill_next       = '0;
                restart_next    = 1'b0;
                run_active_next = 1'b1;
            end else begin
                err_next = err_inc;
                if (run_active_reg) begin
                    restart_next = 1'b1;
                end
                // drop the oldest byte, keep four held
                for (int i = 0; i < rsfs_pkg::HOLD_LEN - 1; i++) begin
                    window_next[i] = window_reg[i+1];
                end
                window_next[rsfs_pkg::HOLD_LEN-1] = rx_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < rsfs_pkg::HOLD_LEN; i++) begin
                window_reg[i] <= 8'd0;
            end
            fill_reg       <= '0;
            err_reg        <= '0;
            run_active_reg <= 1'b0;
            restart_reg    <= 1'b1;
        end else begin
            window_reg     <= window_next;
            fill_reg       <= fill_next;
            err_reg        <= err_next;
            run_active_reg <= run_active_next;
            restart_reg    <= restart_next;
        end
    end

endmodule

/* hw/rtl/rsfs_out_reg.sv */
module rsfs_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  rsfs_pkg::result_t load_data,
    output logic              busy,
    input  logic              m_ready,
    output logic              m_valid,
    output rsfs_pkg::result_t m_data
);

    logic valid_reg, valid_next;
    rsfs_pkg::result_t data_reg;

    assign m_valid = valid_reg;
    assign m_data  = data_reg;
    // full and not drained this cycle
    assign busy = valid_reg && !m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

endmodule

/* hw/rtl/rate_sensor_frame_sync_unit.sv */
// a byte is registered at acceptance; as it leaves the input register, any result it
// completes is registered for the m_ ports; throughput: one byte per cycle unless a
// byte completing a window meets a busy output register; the five-byte add and compare
// sits between the input and result registers, and the window updates as each byte
// leaves the input register; synchronous active-low reset empties the window, clears
// the error count and the run flag, and marks the next good frame as a new run
module rate_sensor_frame_sync_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_frame_good,
    output logic signed [23:0] m_rate_sample,
    output logic [7:0]         m_status_bits,
    output logic               m_run_start,
    output logic [15:0]        m_error_total
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       has_result;
    logic       out_busy;
    logic       advance;
    rsfs_pkg::result_t result;
    rsfs_pkg::result_t out_data;

    // a byte that only fills the window moves on even when the output is stalled
    assign advance = in_valid_reg && !(has_result && out_busy);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    rsfs_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .rx_byte    (in_byte_reg),
        .has_result (has_result),
        .result     (result)
    );

    rsfs_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && has_result),
        .load_data (result),
        .busy      (out_busy),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (out_data)
    );

    assign m_frame_good  = out_data.frame_good;
    assign m_rate_sample = out_data.rate_sample;
    assign m_status_bits = out_data.status_bits;
    assign m_run_start   = out_data.run_start;
    assign m_error_total = out_data.error_total;

endmodule

/* tb/sv/rsfs_frame_checker.sv */
module rsfs_frame_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_frame_good,
    input  logic signed [23:0] m_rate_sample,
    input  logic [7:0]         m_status_bits,
    input  logic               m_run_start,
    input  logic [15:0]        m_error_total,
    output int                 mismatch_count,
    output int                 frames_owed,
    output int                 good_frames,
    output int                 sync_errors
);

    localparam int PRINT_CAP = 30;

    // predicted sync state
    logic [7:0]                  held [rsfs_pkg::HOLD_LEN];
    logic [rsfs_pkg::FILL_W-1:0] held_n;
    logic [15:0]                 err_tally;
    logic                        run_on;
    logic                        new_run_due;

    rsfs_pkg::result_t owed_q [$];
    rsfs_pkg::result_t want;
    int      n_bad = 0;
    int      n_good = 0;
    int      n_err = 0;

    task automatic report_mismatch(input string msg);
        if (n_bad < PRINT_CAP) begin
            $display("rsfs_frame_checker: result %0d: %s", n_good + n_err, msg);
        end
        n_bad++;
    endtask

    task automatic take_byte(input logic [7:0] b);
        logic [7:0]        sum;
        rsfs_pkg::result_t r;
        if (held_n < rsfs_pkg::FILL_W'(rsfs_pkg::HOLD_LEN)) begin
            held[held_n[1:0]] = b;
            held_n = held_n + 1'b1;
        end else begin
            sum = b + held[0] + held[1] + held[2] + held[3];
            r = '0;
            if (sum == rsfs_pkg::SUM_TARGET) begin
                r.frame_good  = 1'b1;
                r.rate_sample = {held[0], held[1], held[2]};
                r.status_bits = held[3];
                r.run_start   = new_run_due;
                r.error_total = err_tally;
                new_run_due = 1'b0;
                run_on = 1'b1;
                held_n = '0;
                foreach (held[i]) held[i] = '0;
            end else begin
                if (err_tally != rsfs_pkg::ERR_MAX) err_tally = err_tally + 1'b1;
                if (run_on) new_run_due = 1'b1;
                // slide the window by one byte
                held[0] = held[1];
                held[1] = held[2];
                held[2] = held[3];
                held[3] = b;
                r.error_total = err_tally;
            end
            owed_q.push_back(r);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (held[i]) held[i] = '0;
            held_n = '0;
            err_tally = '0;
            run_on = 1'b0;
            new_run_due = 1'b1;
            owed_q.delete();
        end else begin
            if (s_valid && s_ready) take_byte(s_rx_byte);
            if (m_valid && m_ready) begin
                if (owed_q.size() == 0) begin
                    report_mismatch("result with no frame owed");
                end else begin
                    want = owed_q.pop_front();
                    if (m_frame_good !== want.frame_good)
                        report_mismatch($sformatf("frame_good got %0b want %0b",
                            m_frame_good, want.frame_good));
                    if (m_rate_sample !== want.rate_sample)
                        report_mismatch($sformatf("rate_sample got %0d want %0d",
                            m_rate_sample, want.rate_sample));
                    if (m_status_bits !== want.status_bits)
                        report_mismatch($sformatf("status_bits got %02h want %02h",
                            m_status_bits, want.status_bits));
                    if (m_run_start !== want.run_start)
                        report_mismatch($sformatf("run_start got %0b want %0b",
                            m_run_start, want.run_start));
                    if (m_error_total !== want.error_total)
                        report_mismatch($sformatf("error_total got %0d want %0d",
                            m_error_total, want.error_total));
                    if (want.frame_good) n_good++;
                    else n_err++;
                end
            end
        end
        mismatch_count <= n_bad;
        frames_owed    <= owed_q.size();
        good_frames    <= n_good;
        sync_errors    <= n_err;
    end

endmodule

/* tb/sv/tb_rate_sensor_frame_sync_unit.sv */
module tb_rate_sensor_frame_sync_unit;

    localparam int TARGET_BYTES    = 950;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 5000;
    localparam int SETTLE_CYCLES   = 6;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_rx_byte = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_frame_good;
    logic signed [23:0] m_rate_sample;
    logic [7:0]         m_status_bits;
    logic               m_run_start;
    logic [15:0]        m_error_total;

    int mismatch_count;
    int frames_owed;
    int good_frames;
    int sync_errors;

    int bytes_sent = 0;
    int idle_run = 0;
    bit pace_on = 1'b1;
    bit hold_off_req = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    rate_sensor_frame_sync_unit u_dut (.*);

    rsfs_frame_checker u_checker (.*);

    // watchdog: cycles in which no request moves on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_run <= 0;
        end else begin
            idle_run <= idle_run + 1;
        end
        if (idle_run >= STALL_LIMIT) begin
            $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
            $display("tb_rate_sensor_frame_sync_unit: FAIL");
            $finish;
        end
    end

    // result side back-pressure
    initial begin : sink
        int wait_n;
        bit choosy;
        choosy = 1'b1;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if ($urandom_range(0, 29) == 0) choosy = ~choosy;
            wait_n = choosy ? $urandom_range(0, 18) : 0;
            if (hold_off_req) begin
                wait_n = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (wait_n > 0) begin
                m_ready <= 1'b0;
                repeat (wait_n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pace_on ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!(s_valid && s_ready));
        bytes_sent++;
    endtask

    // four data bytes and a trailer that makes the sum 0xff, unless ck_flip spoils it
    task automatic send_frame(input logic [23:0] rate, input logic [7:0] status,
                              input logic [7:0] ck_flip);
        logic [7:0] ck;
        ck = rsfs_pkg::SUM_TARGET - (rate[23:16] + rate[15:8] + rate[7:0] + status);
        send_byte(rate[23:16]);
        send_byte(rate[15:8]);
        send_byte(rate[7:0]);
        send_byte(status);
        send_byte(ck ^ ck_flip);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (frames_owed != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        int pick;
        int n;
        bit squeezed;
        squeezed = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // first good frame after reset starts a run, largest positive rate
        send_frame(24'h7FFFFF, 8'hFF, 8'h00);
        send_frame(24'h800000, 8'h00, 8'h00);
        // all-ones window fails its checksum and flags a restart
        repeat (5) send_byte(8'hFF);
        // resyncs after four more errors, next good frame is a new run
        send_frame(24'h123456, 8'hA5, 8'h00);
        send_frame(24'h000000, 8'h00, 8'h00);
        wait_drained();

        while (bytes_sent < TARGET_BYTES) begin
            if ($urandom_range(0, 19) == 0) pace_on = ~pace_on;
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_frame(24'($urandom), 8'($urandom), 8'h00);
            end else if (pick < 85) begin
                send_frame(24'($urandom), 8'($urandom), 8'($urandom_range(1, 255)));
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(8'($urandom));
            end
            if (!squeezed && bytes_sent >= TARGET_BYTES / 2) begin
                // stall the result side while bytes keep coming
                hold_off_req = 1'b1;
                pace_on = 1'b0;
                repeat (60) send_byte(8'($urandom));
                wait_drained();
                squeezed = 1'b1;
            end else if ($urandom_range(0, 49) == 0) begin
                wait_drained();
            end
        end
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("summary: %0d bytes sent, %0d good frames and %0d checksum errors checked",
            bytes_sent, good_frames, sync_errors);
        $display("summary: rate extremes, new-run marking, resync and a long output stall");
        if (mismatch_count == 0) begin
            $display("tb_rate_sensor_frame_sync_unit: PASS");
        end else begin
            $display("tb_rate_sensor_frame_sync_unit: FAIL");
        end
        $finish;
    end

endmodule

/* rate_sensor_frame_sync_unit.f */
hw/rtl/rsfs_pkg.sv
hw/rtl/rsfs_core.sv
hw/rtl/rsfs_out_reg.sv
hw/rtl/rate_sensor_frame_sync_unit.sv
tb/sv/rsfs_frame_checker.sv
tb/sv/tb_rate_sensor_frame_sync_unit.sv
